// ===== sv/lsbd_pkg.sv =====
// Shared types and constants for the LCD shadow-buffer differential writer.
`timescale 1ns / 1ps

package lsbd_pkg;

  // Display geometry
  localparam int LINE_WIDTH = 20;
  localparam int LINE_COUNT = 4;
  localparam int DEPTH      = LINE_WIDTH * LINE_COUNT;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths
  localparam int COL_W  = 5;
  localparam int ROW_W  = 2;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Input request codes
  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_CHAR = 1'b1;

  // Output command codes
  localparam logic CMD_CURSOR = 1'b0;
  localparam logic CMD_PRINT  = 1'b1;

  typedef enum logic {
    KIND_MOVE,
    KIND_CHAR
  } kind_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    B_EMPTY,
    B_CHECK,
    B_PRINT
  } bstate_e;

  // One classified operation handed from front to back
  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  addr;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [CHAR_W-1:0]  ch;
  } entry_t;

  // Queue write side
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Queue read side
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// ===== sv/lcd_shadow_buffer_diff_writer.sv =====
// Top level of the LCD shadow-buffer differential writer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | input     | in_valid_i/in_ready_o | req_type, column, row, char_code
//  out     | output    | out_valid_o/out_ready_i | command, out_column, out_row, out_char, last
//
// An item is accepted whenever the queue has room; the front keeps up every cycle.
// The back handles one queued operation at a time in B_CHECK; a changed character that also
// needs a set-cursor command goes on to B_PRINT; the single output register port sets the pace.
// A printed item passes from a queue slot through cur_q into the output register.
// Reset clears the per-cell written flags at once, so the shadow reads as spaces; no sweep.
// A stalled output holds the back, which fills the four-entry queue and then drops in_ready_o.
`timescale 1ns / 1ps

module lcd_shadow_buffer_diff_writer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [lsbd_pkg::COL_W-1:0]   column_i,
  input  logic [lsbd_pkg::ROW_W-1:0]   row_i,
  input  logic [lsbd_pkg::CHAR_W-1:0]  char_code_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         command_o,
  output logic [lsbd_pkg::COL_W-1:0]   out_column_o,
  output logic [lsbd_pkg::ROW_W-1:0]   out_row_o,
  output logic [lsbd_pkg::CHAR_W-1:0]  out_char_o,
  output logic                         last_o
);

  lsbd_pkg::push_t push;
  lsbd_pkg::head_t head;
  logic            q_ready;
  logic            pop;

  assign in_ready_o = q_ready;

  lsbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .q_ready_i   (q_ready),
    .req_type_i  (req_type_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .char_code_i (char_code_i),
    .push_o      (push)
  );

  lsbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  lsbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .command_o    (command_o),
    .out_column_o (out_column_o),
    .out_row_o    (out_row_o),
    .out_char_o   (out_char_o),
    .last_o       (last_o)
  );

endmodule

// ===== sv/lsbd_front.sv =====
// Front end: tracks cursor position, drops off-screen characters, classifies items.
`timescale 1ns / 1ps

module lsbd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          q_ready_i,
  input  logic                          req_type_i,
  input  logic [lsbd_pkg::COL_W-1:0]    column_i,
  input  logic [lsbd_pkg::ROW_W-1:0]    row_i,
  input  logic [lsbd_pkg::CHAR_W-1:0]   char_code_i,
  output lsbd_pkg::push_t               push_o
);

  logic [lsbd_pkg::COL_W-1:0] col_q, col_d;
  logic [lsbd_pkg::ROW_W-1:0] row_q, row_d;
  logic                       full_q, full_d;
  logic                       accept;
  logic                       on_screen;
  logic [lsbd_pkg::ADDR_W-1:0] addr;

  assign accept = in_valid_i && q_ready_i;

  // Position checks and linear shadow address
  assign on_screen = !full_q
                  && (6'(col_q) < 6'(lsbd_pkg::LINE_WIDTH))
                  && (3'(row_q) < 3'(lsbd_pkg::LINE_COUNT));
  assign addr = lsbd_pkg::ADDR_W'(32'(row_q) * 32'(lsbd_pkg::LINE_WIDTH) + 32'(col_q));

  // Next position and queue push
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    full_d = full_q;
    push_o = '0;
    push_o.entry.col  = col_q;
    push_o.entry.row  = row_q;
    push_o.entry.ch   = char_code_i;
    push_o.entry.addr = addr;
    if (req_type_i == lsbd_pkg::REQ_MOVE) begin
      push_o.entry.kind = lsbd_pkg::KIND_MOVE;
      push_o.valid      = in_valid_i;
      if (accept) begin
        col_d  = column_i;
        row_d  = row_i;
        full_d = 1'b0;
      end
    end else begin
      push_o.entry.kind = lsbd_pkg::KIND_CHAR;
      push_o.valid      = in_valid_i && on_screen;
      if (accept && on_screen) begin
        if (col_q == '1) begin
          full_d = 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      full_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      full_q <= full_d;
    end
  end

endmodule

// ===== sv/lsbd_queue.sv =====
// Short queue of classified operations between front and back.
`timescale 1ns / 1ps

module lsbd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lsbd_pkg::push_t  push_i,
  output logic             ready_o,
  output lsbd_pkg::head_t  head_o,
  input  logic             pop_i
);

  lsbd_pkg::entry_t            slot_q [lsbd_pkg::QDEPTH];
  logic [lsbd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [lsbd_pkg::QPTR_W:0]   count_q;
  logic                        do_push, do_pop;

  assign ready_o = (count_q != (lsbd_pkg::QPTR_W+1)'(lsbd_pkg::QDEPTH));
  assign do_push = push_i.valid && ready_o;
  assign do_pop  = pop_i && head_o.valid;

  assign head_o.valid = (count_q != '0);
  assign head_o.entry = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== sv/lsbd_back.sv =====
// Back end: shadow memory lookup, change detection and command emission.
`timescale 1ns / 1ps

module lsbd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lsbd_pkg::head_t              head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         command_o,
  output logic [lsbd_pkg::COL_W-1:0]   out_column_o,
  output logic [lsbd_pkg::ROW_W-1:0]   out_row_o,
  output logic [lsbd_pkg::CHAR_W-1:0]  out_char_o,
  output logic                         last_o
);

  lsbd_pkg::bstate_e           state_q, state_d;
  lsbd_pkg::entry_t            cur_q;
  logic [lsbd_pkg::CHAR_W-1:0] mem_q [lsbd_pkg::DEPTH];
  logic [lsbd_pkg::DEPTH-1:0]  written_q;
  logic [lsbd_pkg::CHAR_W-1:0] rd_data_q;
  logic                        rd_hit_q;
  logic                        pending_q, pending_d;
  logic                        out_valid_q;
  logic                        cmd_q, last_q;
  logic [lsbd_pkg::COL_W-1:0]  ocol_q;
  logic [lsbd_pkg::ROW_W-1:0]  orow_q;
  logic [lsbd_pkg::CHAR_W-1:0] ochar_q;

  logic                        out_free;
  logic                        done;
  logic                        wr_en;
  logic                        fwd;
  logic                        load_cursor, load_print;
  logic [lsbd_pkg::CHAR_W-1:0] shadow;
  logic                        differ;

  assign out_free = !out_valid_q || out_ready_i;
  assign shadow   = rd_hit_q ? rd_data_q : lsbd_pkg::SPACE_CODE;
  assign differ   = (cur_q.kind == lsbd_pkg::KIND_CHAR) && (shadow != cur_q.ch);

  // Sequencer: one operation at a time, next one is read while this one finishes
  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    done        = 1'b0;
    wr_en       = 1'b0;
    load_cursor = 1'b0;
    load_print  = 1'b0;
    unique case (state_q)
      lsbd_pkg::B_EMPTY: begin
        done = 1'b0;
      end
      lsbd_pkg::B_CHECK: begin
        if (!differ) begin
          done      = 1'b1;
          pending_d = 1'b1;
        end else if (out_free) begin
          if (pending_q) begin
            load_cursor = 1'b1;
            state_d     = lsbd_pkg::B_PRINT;
          end else begin
            load_print = 1'b1;
            wr_en      = 1'b1;
            done       = 1'b1;
            pending_d  = 1'b0;
          end
        end
      end
      lsbd_pkg::B_PRINT: begin
        if (out_free) begin
          load_print = 1'b1;
          wr_en      = 1'b1;
          done       = 1'b1;
          pending_d  = 1'b0;
        end
      end
      default: state_d = lsbd_pkg::B_EMPTY;
    endcase
    pop_o = head_i.valid && ((state_q == lsbd_pkg::B_EMPTY) || done);
    if (done || state_q == lsbd_pkg::B_EMPTY) begin
      state_d = pop_o ? lsbd_pkg::B_CHECK : lsbd_pkg::B_EMPTY;
    end
  end

  // Read-after-write on the same cell takes the data being written
  assign fwd = wr_en && (cur_q.addr == head_i.entry.addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lsbd_pkg::B_EMPTY;
      pending_q <= 1'b1;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
    end
  end

  // Shadow memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cur_q.addr] <= cur_q.ch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q     <= head_i.entry;
      rd_data_q <= fwd ? cur_q.ch : mem_q[head_i.entry.addr];
    end
  end

  // Per-cell written flags; an unwritten cell reads as a space
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        written_q[cur_q.addr] <= 1'b1;
      end
      if (pop_o) begin
        rd_hit_q <= fwd || written_q[head_i.entry.addr];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= load_cursor || load_print;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cursor) begin
      cmd_q   <= lsbd_pkg::CMD_CURSOR;
      ocol_q  <= cur_q.col;
      orow_q  <= cur_q.row;
      ochar_q <= '0;
      last_q  <= 1'b0;
    end else if (load_print) begin
      cmd_q   <= lsbd_pkg::CMD_PRINT;
      ocol_q  <= '0;
      orow_q  <= '0;
      ochar_q <= cur_q.ch;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign command_o    = cmd_q;
  assign out_column_o = ocol_q;
  assign out_row_o    = orow_q;
  assign out_char_o   = ochar_q;
  assign last_o       = last_q;

endmodule

// ===== sv/lsbd_checker.sv =====
// Port-level checks for the LCD shadow-buffer differential writer, with bind.
`timescale 1ns / 1ps

module lsbd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         command_o,
  input logic [lsbd_pkg::COL_W-1:0]   out_column_o,
  input logic [lsbd_pkg::ROW_W-1:0]   out_row_o,
  input logic [lsbd_pkg::CHAR_W-1:0]  out_char_o,
  input logic                         last_o
);

  // Stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_o)
      && $stable(out_column_o) && $stable(out_row_o) && $stable(out_char_o)
      && $stable(last_o))
    else $error("stalled result changed");

  // Set-cursor result is never last, carries no char and points on screen
  a_cursor_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == lsbd_pkg::CMD_CURSOR |-> !last_o && out_char_o == '0
      && (6'(out_column_o) < 6'(lsbd_pkg::LINE_WIDTH))
      && (3'(out_row_o) < 3'(lsbd_pkg::LINE_COUNT)))
    else $error("bad set-cursor result");

  // Print result always closes its item
  a_print_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == lsbd_pkg::CMD_PRINT |-> last_o && out_column_o == '0
      && out_row_o == '0)
    else $error("bad print result");

  // A set-cursor transaction is followed right away by its print
  a_cursor_then_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && command_o == lsbd_pkg::CMD_CURSOR
      |=> out_valid_o && command_o == lsbd_pkg::CMD_PRINT)
    else $error("set-cursor not followed by print");

endmodule

bind lcd_shadow_buffer_diff_writer lsbd_checker u_lsbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .command_o    (command_o),
  .out_column_o (out_column_o),
  .out_row_o    (out_row_o),
  .out_char_o   (out_char_o),
  .last_o       (last_o)
);
